@@ rtl/acl21_pkg.sv @@
// ----------------------------------------------------------------------------
// acl21_pkg
// Types, codes and lookup functions for the 21-letter affine cipher.
// ----------------------------------------------------------------------------
package acl21_pkg;

  // Alphabet size and letter landmarks
  localparam logic [4:0] ALPHA_SIZE = 5'd21;
  localparam logic [4:0] ALPHA_LAST = 5'd20;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_I       = 8'h49;
  localparam logic [7:0] CH_L       = 8'h4C;
  localparam logic [7:0] CH_V       = 8'h56;
  localparam logic [7:0] CH_Z       = 8'h5A;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_Z   = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // Reciprocal of 21 for the reduction: floor(v * 195 / 4096) is q or q - 1
  localparam logic [7:0] RECIP_MUL   = 8'd195;
  localparam int unsigned RecipShift = 12;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FOREIGN = 2'd1;
  localparam logic [1:0] ST_BAD_KEY = 2'd2;

  // Configuration register indexes
  localparam logic CFG_KEY_MULT  = 1'b0;
  localparam logic CFG_KEY_SHIFT = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] status;
  } out_item_t;

  // Decode stage contents
  typedef struct packed {
    logic       xform;
    logic       lower;
    logic       mode;
    logic [4:0] x;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] inv;
    logic [7:0] char_raw;
    logic [1:0] status;
  } s1_t;

  // Product stage contents
  typedef struct packed {
    logic       xform;
    logic       lower;
    logic [8:0] sum;
    logic [7:0] char_raw;
    logic [1:0] status;
  } s2_t;

  function automatic logic [4:0] reduce_key(input logic [4:0] v);
    return (v >= ALPHA_SIZE) ? v - ALPHA_SIZE : v;
  endfunction

  // Inverse mod 21, zero where none exists
  function automatic logic [4:0] inv_mod21(input logic [4:0] a);
    logic [4:0] r;
    case (a)
      5'd1:    r = 5'd1;
      5'd2:    r = 5'd11;
      5'd4:    r = 5'd16;
      5'd5:    r = 5'd17;
      5'd8:    r = 5'd8;
      5'd10:   r = 5'd19;
      5'd11:   r = 5'd2;
      5'd13:   r = 5'd13;
      5'd16:   r = 5'd4;
      5'd17:   r = 5'd5;
      5'd19:   r = 5'd10;
      5'd20:   r = 5'd20;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/acl21_letter_out.sv @@
// ----------------------------------------------------------------------------
// acl21_letter_out
// Reduces the affine sum mod 21 and maps the index back to an ASCII letter.
// ----------------------------------------------------------------------------
module acl21_letter_out
  import acl21_pkg::*;
(
  input  s2_t       s2,
  output out_item_t item
);

  logic [16:0] q_full;
  logic [4:0]  q_est;
  logic [8:0]  prod21;
  logic [8:0]  rem;
  logic [4:0]  y;
  logic [7:0]  upper;
  logic [7:0]  letter;

  // Estimate the quotient low by at most one, then correct once
  assign q_full = {8'd0, s2.sum} * {9'd0, RECIP_MUL};
  assign q_est  = q_full[RecipShift +: 5];
  assign prod21 = {4'd0, q_est} * {4'd0, ALPHA_SIZE};
  assign rem    = s2.sum - prod21;
  assign y      = (rem >= {4'd0, ALPHA_SIZE}) ? 5'(rem - {4'd0, ALPHA_SIZE}) : rem[4:0];

  always_comb begin
    if (y <= 5'd8) begin
      upper = CH_A + {3'd0, y};
    end else if (y <= 5'd19) begin
      upper = CH_A + {3'd0, y} + 8'd2;
    end else begin
      upper = CH_Z;
    end
    letter = s2.lower ? (upper | CASE_BIT) : upper;
  end

  assign item.char_out = s2.xform ? letter : s2.char_raw;
  assign item.status   = s2.status;

endmodule

@@ rtl/affine_cipher_21_letter.sv @@
// ----------------------------------------------------------------------------
// affine_cipher_21_letter
// Affine cipher over the 21-letter Italian alphabet, one byte per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries a mode bit and an ASCII
//   byte; the result channel (out_valid/out_ready/out_data) carries the byte
//   after the cipher and a status code. Each transfer in gives exactly one
//   transfer out, in order.
//   Keys are written through cfg_we/cfg_index/cfg_data while the block is
//   idle: index 0 is the multiplicative key a, index 1 the additive key b.
//   An input transfer passes through three registers, one per stage, before
//   the matching output transfer. Stages:
//   decode, multiply-add, mod-21 reduction into the output register.
//   Throughput is one item per cycle while out_ready stays high.
//   Reset empties the pipeline and loads a = 1, b = 0.
//   When the receiver stalls, the output holds; the stages behind it keep
//   advancing into empty slots, so up to three items are held before
//   in_ready falls.
// ----------------------------------------------------------------------------
module affine_cipher_21_letter
  import acl21_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [4:0] cfg_data
);

  // Key registers
  logic [4:0] key_mult_r, key_mult_nxt;
  logic [4:0] key_shift_r, key_shift_nxt;

  // Pipeline registers with their valid bits
  logic      v1_r, v1_nxt;
  logic      v2_r, v2_nxt;
  logic      v3_r, v3_nxt;
  s1_t       s1_r, s1_nxt;
  s2_t       s2_r, s2_nxt;
  out_item_t s3_r, s3_nxt;

  logic rdy1, rdy2, rdy3;

  // Stage 1 decode signals
  logic [7:0] ch;
  logic [7:0] up;
  logic       is_upper, is_lower, is_letter, foreign;
  logic [4:0] x, a, b, inv;
  logic       key_ok;

  // Stage 2 arithmetic signals
  logic [5:0] d_wide;
  logic [4:0] d, m1, m2;
  logic [9:0] prod;

  out_item_t mapped;

  // A stage may take a new item when empty or when its contents move on
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign out_valid = v3_r;
  assign out_data  = s3_r;

  // Configuration writes
  always_comb begin
    key_mult_nxt  = key_mult_r;
    key_shift_nxt = key_shift_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_MULT:  key_mult_nxt  = cfg_data;
        CFG_KEY_SHIFT: key_shift_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: classify the byte and fetch the reduced keys
  always_comb begin
    ch        = in_data.char_in;
    up        = ch & ~CASE_BIT;
    is_upper  = (ch >= CH_A) && (ch <= CH_Z);
    is_lower  = (ch >= CH_LOW_A) && (ch <= CH_LOW_Z);
    is_letter = is_upper || is_lower;
    foreign   = 1'b0;
    if ((up >= CH_A) && (up <= CH_I)) begin
      x = 5'(up - CH_A);
    end else if ((up >= CH_L) && (up <= CH_V)) begin
      x = 5'(up - CH_A - 8'd2);
    end else if (up == CH_Z) begin
      x = ALPHA_LAST;
    end else begin
      x       = 5'd0;
      foreign = 1'b1;
    end
    a      = reduce_key(key_mult_r);
    b      = reduce_key(key_shift_r);
    inv    = inv_mod21(a);
    key_ok = (inv != 5'd0);

    s1_nxt          = s1_r;
    s1_nxt.xform    = is_letter && !foreign && key_ok;
    s1_nxt.lower    = is_lower;
    s1_nxt.mode     = in_data.mode;
    s1_nxt.x        = x;
    s1_nxt.a        = a;
    s1_nxt.b        = b;
    s1_nxt.inv      = inv;
    s1_nxt.char_raw = ch;
    if (is_letter && foreign) begin
      s1_nxt.status = ST_FOREIGN;
    end else if (!key_ok) begin
      s1_nxt.status = ST_BAD_KEY;
    end else begin
      s1_nxt.status = ST_OK;
    end
  end

  // Stage 2: encrypt is inv*x + b, decrypt is a*((x - b) mod 21)
  always_comb begin
    d_wide = ({1'b0, s1_r.x} >= {1'b0, s1_r.b})
             ? {1'b0, s1_r.x} - {1'b0, s1_r.b}
             : {1'b0, s1_r.x} + {1'b0, ALPHA_SIZE} - {1'b0, s1_r.b};
    d      = d_wide[4:0];
    m1     = s1_r.mode ? s1_r.a : s1_r.inv;
    m2     = s1_r.mode ? d : s1_r.x;
    prod   = {5'd0, m1} * {5'd0, m2};

    s2_nxt          = s2_r;
    s2_nxt.xform    = s1_r.xform;
    s2_nxt.lower    = s1_r.lower;
    s2_nxt.sum      = prod[8:0] + (s1_r.mode ? 9'd0 : {4'd0, s1_r.b});
    s2_nxt.char_raw = s1_r.char_raw;
    s2_nxt.status   = s1_r.status;
  end

  // Stage 3: reduce mod 21 and rebuild the letter
  acl21_letter_out u_letter_out (
    .s2   (s2_r),
    .item (mapped)
  );

  assign s3_nxt = mapped;

  // Valid bits advance wherever the stage ahead has room
  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r     : v2_r;
    v3_nxt = rdy3 ? v2_r     : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mult_r  <= 5'd1;
      key_shift_r <= 5'd0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      key_mult_r  <= key_mult_nxt;
      key_shift_r <= key_shift_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
    end
  end

  // Payload: load only on a transfer into the stage, otherwise hold
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1_r <= s1_nxt;
    end
    if (v1_r && rdy2) begin
      s2_r <= s2_nxt;
    end
    if (v2_r && rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  // An input transfer always lands in stage 1
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("input transfer did not reach stage 1");

  // A blocked stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |=> (v1_r && $stable(s1_r)))
    else $error("stage 1 item lost during stall");

  // A blocked stage 2 keeps its item
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(s2_r)))
    else $error("stage 2 item lost during stall");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_FOREIGN ||
                   out_data.status == ST_BAD_KEY))
    else $error("undefined status code on output");

endmodule

@@ test/affine_cipher_21_letter_chk.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_cipher_21_letter_chk
// Watches the key port and both channels of the 21-letter affine cipher. It
// predicts the cipher byte and status of every accepted character and
// compares them, in order, with the results that leave the block.
// ----------------------------------------------------------------------------
module affine_cipher_21_letter_chk
  import acl21_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data,
  output int unsigned mismatches,
  output int unsigned chars_in_flight
);

  out_item_t  expected_chars[$];
  logic [4:0] key_a;
  logic [4:0] key_b;

  initial begin
    mismatches      = 0;
    chars_in_flight = 0;
  end

  function automatic int fold21(input logic [4:0] v);
    return (v >= 5'd21) ? int'(v) - 21 : int'(v);
  endfunction

  // Multiplicative inverse mod 21 by search; 0 when the key shares a factor
  function automatic int recip21(input int a);
    int r;
    r = 0;
    for (int k = 1; k < 21; k++) begin
      if ((a * k) % 21 == 1) r = k;
    end
    return r;
  endfunction

  function automatic out_item_t cipher_char(input logic mode, input logic [7:0] ch,
                                            input logic [4:0] a_reg, input logic [4:0] b_reg);
    int         a;
    int         b;
    int         inv;
    int         x;
    int         y;
    logic       upper;
    logic       lower;
    logic [7:0] up;
    out_item_t  r;
    a     = fold21(a_reg);
    b     = fold21(b_reg);
    inv   = recip21(a);
    upper = (ch >= CH_A) && (ch <= CH_Z);
    lower = (ch >= CH_LOW_A) && (ch <= CH_LOW_Z);
    r.char_out = ch;
    r.status   = ST_OK;
    if (upper || lower) begin
      up = lower ? ch - CASE_BIT : ch;
      if (up <= CH_I) x = int'(up - CH_A);
      else if (up >= CH_L && up <= CH_V) x = int'(up - CH_A) - 2;
      else if (up == CH_Z) x = 20;
      else x = 21;
      if (x == 21) begin
        // J, K, W, X and Y: flagged whatever the key
        r.status = ST_FOREIGN;
      end else if (inv == 0) begin
        r.status = ST_BAD_KEY;
      end else begin
        if (mode == 1'b0) y = (inv * x + b) % 21;
        else y = (a * ((x + 21 - b) % 21)) % 21;
        if (y <= 8) up = CH_A + 8'(y);
        else if (y <= 19) up = CH_A + 8'(y + 2);
        else up = CH_Z;
        r.char_out = lower ? (up | CASE_BIT) : up;
      end
    end else if (inv == 0) begin
      r.status = ST_BAD_KEY;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      key_a = 5'd1;
      key_b = 5'd0;
      expected_chars.delete();
      chars_in_flight = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("result char_out=%02h status=%0d with nothing expected",
                 out_data.char_out, out_data.status);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.char_out !== want.char_out) begin
            $error("char_out: expected %02h, got %02h", want.char_out, out_data.char_out);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
        end
      end
      // Predict with the keys in force before any write at this edge
      if (in_valid && in_ready)
        expected_chars.push_back(cipher_char(in_data.mode, in_data.char_in, key_a, key_b));
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_MULT) key_a = cfg_data;
        else key_b = cfg_data;
      end
      chars_in_flight = expected_chars.size();
    end
  end

endmodule

@@ test/affine_cipher_21_letter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_cipher_21_letter_tb
// Drives characters through the 21-letter affine cipher under a series of
// keys, from a short directed set of boundary letters, foreign letters and
// non-letters to bursts of random text, while the receiver stalls on its own
// pattern. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module affine_cipher_21_letter_tb;
  import acl21_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned KEY_PHASES      = 8;
  localparam int unsigned CHARS_PER_PHASE = 210;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_style_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [4:0]  cfg_data;

  int unsigned mismatches;
  int unsigned chars_in_flight;
  int unsigned cycle_count;

  rx_style_t   rx_style;
  int unsigned rx_left;
  int unsigned rx_tick;

  // Boundary letters either side of the gaps, case extremes, a foreign letter
  // in each case, the neighbours of the letter ranges and the byte extremes
  logic [7:0] probe_chars [13] = '{
    CH_A, CH_Z, CH_LOW_A, CH_LOW_Z, CH_I, CH_L, CH_V,
    8'h6A, 8'h57, 8'h40, 8'h60, 8'hFF, 8'h00
  };

  // Key pairs per phase: reset values, upper extremes, a zero key a, values
  // above 20 that fold back (31 to 10, 21 to 0), and a non-coprime key a
  logic [4:0] mult_keys  [KEY_PHASES] = '{5'd1, 5'd20, 5'd0, 5'd31, 5'd2, 5'd21, 5'd7, 5'd1};
  logic [4:0] shift_keys [KEY_PHASES] = '{5'd0, 5'd20, 5'd5, 5'd31, 5'd19, 5'd24, 5'd0, 5'd0};

  affine_cipher_21_letter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  affine_cipher_21_letter_chk u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .chars_in_flight (chars_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run if the traffic never drains
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: switch between free flow, coin tosses, sparse readiness and a fixed
  // duty cycle, holding each style for a random stretch
  initial begin
    rx_style = RX_FLOW;
    rx_left  = 0;
    rx_tick  = 0;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_left  = $urandom_range(30, 200);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_style)
      RX_FLOW:     out_ready <= 1'b1;
      RX_COIN:     out_ready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= ((rx_tick % 8) < 5);
    endcase
  end

  // Present one character and hold it until the transfer; return on the
  // following falling edge with valid still high
  task automatic send_char(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid for a gap between bursts
  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Stop sending and wait until every result has left
  task automatic drain_block();
    in_valid <= 1'b0;
    while (chars_in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both keys on consecutive cycles while the block is idle
  task automatic load_keys(input logic [4:0] mult, input logic [4:0] shift);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_MULT;
    cfg_data  <= mult;
    @(negedge clk);
    cfg_index <= CFG_KEY_SHIFT;
    cfg_data  <= shift;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    in_item_t    item;
    int unsigned burst_left;
    logic [4:0]  mult;
    logic [4:0]  shift;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_KEY_MULT;
    cfg_data  = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: each probe character in both modes under a good key
    load_keys(5'd5, 5'd7);
    for (int k = 0; k < 13; k++) begin
      for (int m = 0; m < 2; m++) begin
        item.mode    = m[0];
        item.char_in = probe_chars[k];
        send_char(item);
      end
    end

    // Random text under each key pair, in bursts with gaps
    for (int p = 0; p < KEY_PHASES; p++) begin
      drain_block();
      mult  = (p == KEY_PHASES - 1) ? 5'($urandom_range(0, 31)) : mult_keys[p];
      shift = (p == KEY_PHASES - 1) ? 5'($urandom_range(0, 31)) : shift_keys[p];
      load_keys(mult, shift);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < CHARS_PER_PHASE; n++) begin
        // Pause once mid-phase until the pipeline is empty
        if (p == 3 && n == CHARS_PER_PHASE / 2) drain_block();
        item.mode = 1'($urandom_range(0, 1));
        // Mostly letters of either case, the rest any byte at all
        if ($urandom_range(0, 9) < 6) begin
          item.char_in = CH_A + 8'($urandom_range(0, 25));
          if ($urandom_range(0, 1) == 1) item.char_in = item.char_in | CASE_BIT;
        end else begin
          item.char_in = 8'($urandom_range(0, 255));
        end
        send_char(item);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end else begin
          burst_left--;
        end
      end
    end

    // Let the last results out, then allow for any stray transfer
    in_valid <= 1'b0;
    while (chars_in_flight != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatches == 0 && chars_in_flight == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
